### design/mss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// shared constants and types for the recently used selection set
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 17;
    localparam int OP_W     = 3;
    localparam int SIZE_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_SET_SINGLE   = 3'd0,
        OP_TOGGLE       = 3'd1,
        OP_ERASE        = 3'd2,
        OP_AFTER_REMOVE = 3'd3,
        OP_CONTAINS     = 3'd4,
        OP_READ_SORTED  = 3'd5
    } t_op;

endpackage

### design/mru_selection_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_selection_set_top
// ordered set of distinct indices, most recently toggled first
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream: tuser carries the operation and tdata
// the index. Results leave on the master stream, one beat per command, or one
// beat per stored index for read-sorted on a non-empty set, with tlast on
// the final beat. The set lives in one ram with a registered read port;
// commands that scan walk it one entry per cycle.
// Set-single, rejected toggles, unused codes and read-sorted on an empty set
// load the result beat without a scan; contains, erase, after-remove and
// the other toggles scan the set once, and a toggle that inserts then moves
// every entry one place down and writes the new index at the head.
// Read-sorted runs one full scan per emitted beat, each finding the largest
// index below the one emitted before.
// A new command can be taken in the cycle after the last beat of the previous
// one is loaded, so a stalled receiver holds only that beat.
// While the output register is full and the receiver stalls, the block
// waits with the next beat. Reset empties the set at once; the ram needs
// no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module mru_selection_set_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // index[16:0], zero fill
    input  logic [7:0]  i_s_tuser,   // op[2:0], zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // entry[16:0], flag[17], set_size[24:18], zero fill
    output logic [7:0]  o_m_tuser,   // entry_valid[0], zero fill
    output logic        o_m_tlast
);

    localparam int AW = mss_pkg::ADDR_W;
    localparam int CW = mss_pkg::CNT_W;
    localparam int IW = mss_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SORT,
        S_PUT
    } t_state;

    t_state                r_state;
    t_state                r_ret;
    logic [mss_pkg::OP_W-1:0] r_op;
    logic signed [IW-1:0]  r_idx;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_k;
    logic [AW-1:0]         r_dpos;
    logic                  r_pend;
    logic                  r_found;
    logic                  r_have;
    logic signed [IW-1:0]  r_best;
    logic signed [IW-1:0]  r_bound;
    logic                  r_bound_v;
    logic [CW-1:0]         r_emit;

    logic signed [IW-1:0]  r_res_entry;
    logic                  r_res_valid;
    logic                  r_res_flag;
    logic                  r_res_last;

    logic                  r_ovalid;
    logic signed [IW-1:0]  r_oentry;
    logic                  r_ovld;
    logic                  r_oflag;
    logic [mss_pkg::SIZE_W-1:0] r_osize;
    logic                  r_olast;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [IW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [IW-1:0]         ram_rdata;
    logic signed [IW-1:0]  rd_val;

    logic                  in_fire;
    logic [mss_pkg::OP_W-1:0] in_op;
    logic signed [IW-1:0]  in_idx;
    logic                  scan_issue;
    logic                  shift_issue;
    logic                  scan_done;
    logic                  shift_done;
    logic                  match;
    logic                  cand;
    logic                  wb_en;
    logic                  sort_last;

    assign in_op   = i_s_tuser[mss_pkg::OP_W-1:0];
    assign in_idx  = i_s_tdata[IW-1:0];
    assign in_fire = i_s_tvalid && o_s_tready;
    assign rd_val  = ram_rdata;

    assign scan_issue  = (r_k < r_count);
    assign shift_issue = (r_k != '0);
    assign scan_done   = !scan_issue && !r_pend;
    assign shift_done  = !shift_issue && !r_pend;
    assign match       = r_pend && !r_found && (rd_val == r_idx);
    assign cand        = r_pend && (!r_bound_v || rd_val < r_bound)
                         && (!r_have || rd_val > r_best);
    assign wb_en       = (r_op == mss_pkg::OP_TOGGLE) || (r_op == mss_pkg::OP_ERASE)
                         || (r_op == mss_pkg::OP_AFTER_REMOVE);
    assign sort_last   = (CW'(r_emit + 1'b1) == r_count);

    // ram access
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_k[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && in_op == mss_pkg::OP_SET_SINGLE && !in_idx[IW-1]) begin
                    ram_we    = 1'b1;
                    ram_wdata = in_idx;
                end
            end
            S_SCAN: begin
                ram_re = scan_issue;
                if (r_pend && wb_en && !match) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dpos - AW'(r_found);
                    if (r_op == mss_pkg::OP_AFTER_REMOVE && rd_val > r_idx) begin
                        ram_wdata = rd_val - IW'(1);
                    end else begin
                        ram_wdata = rd_val;
                    end
                end
            end
            S_SHIFT: begin
                ram_re    = shift_issue;
                ram_raddr = AW'(r_k - 1'b1);
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dpos + 1'b1;
                    ram_wdata = rd_val;
                end else if (shift_done) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_idx;
                end
            end
            S_SORT: begin
                ram_re = scan_issue;
            end
            S_PUT: begin
            end
            default: begin
            end
        endcase
    end

    mss_ram #(
        .WIDTH (IW),
        .DEPTH (mss_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // in S_PUT the output register is reloaded below
            if (r_ovalid && i_m_tready && r_state != S_PUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op        <= in_op;
                        r_idx       <= in_idx;
                        r_k         <= '0;
                        r_pend      <= 1'b0;
                        r_found     <= 1'b0;
                        r_have      <= 1'b0;
                        r_bound_v   <= 1'b0;
                        r_emit      <= '0;
                        r_res_entry <= '0;
                        r_res_valid <= 1'b0;
                        r_res_flag  <= 1'b0;
                        r_res_last  <= 1'b1;
                        r_ret       <= S_IDLE;
                        r_state     <= S_PUT;
                        case (in_op)
                            mss_pkg::OP_SET_SINGLE: begin
                                r_count <= in_idx[IW-1] ? '0 : CW'(1);
                            end
                            mss_pkg::OP_TOGGLE: begin
                                if (!in_idx[IW-1]) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            mss_pkg::OP_ERASE, mss_pkg::OP_AFTER_REMOVE,
                            mss_pkg::OP_CONTAINS: begin
                                r_state <= S_SCAN;
                            end
                            mss_pkg::OP_READ_SORTED: begin
                                if (r_count != '0) begin
                                    r_state <= S_SORT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_k    <= r_k + 1'b1;
                        r_dpos <= r_k[AW-1:0];
                    end
                    if (match) begin
                        r_found <= 1'b1;
                    end
                    if (scan_done) begin
                        r_state <= S_PUT;
                        case (r_op)
                            mss_pkg::OP_CONTAINS: begin
                                r_res_flag <= r_found;
                            end
                            mss_pkg::OP_TOGGLE: begin
                                if (r_found) begin
                                    r_count <= r_count - 1'b1;
                                end else if (r_count < CW'(mss_pkg::CAPACITY)) begin
                                    r_k     <= r_count;
                                    r_state <= S_SHIFT;
                                end
                            end
                            default: begin
                                r_count <= r_count - CW'(r_found);
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    r_pend <= shift_issue;
                    if (shift_issue) begin
                        r_k    <= r_k - 1'b1;
                        r_dpos <= AW'(r_k - 1'b1);
                    end
                    if (shift_done) begin
                        r_count    <= r_count + 1'b1;
                        r_res_flag <= 1'b1;
                        r_state    <= S_PUT;
                    end
                end
                S_SORT: begin
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (cand) begin
                        r_have <= 1'b1;
                        r_best <= rd_val;
                    end
                    if (scan_done) begin
                        r_res_entry <= r_best;
                        r_res_valid <= 1'b1;
                        r_res_last  <= sort_last;
                        r_bound     <= r_best;
                        r_bound_v   <= 1'b1;
                        r_emit      <= r_emit + 1'b1;
                        r_k         <= '0;
                        r_have      <= 1'b0;
                        r_ret       <= sort_last ? S_IDLE : S_SORT;
                        r_state     <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_oentry <= r_res_entry;
                        r_ovld   <= r_res_valid;
                        r_oflag  <= r_res_flag;
                        r_osize  <= mss_pkg::SIZE_W'(r_count);
                        r_olast  <= r_res_last;
                        r_state  <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_osize, r_oflag, r_oentry};
    assign o_m_tuser  = {7'd0, r_ovld};
    assign o_m_tlast  = r_olast;

endmodule

### design/mss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_checker
// port-level checks for the selection set, bound to the top level
// ----------------------------------------------------------------------------
module mss_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] o_m_tdata,
    input  logic [7:0]  o_m_tuser,
    input  logic        o_m_tlast
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    a_size_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[24:18] <= 7'(mss_pkg::CAPACITY))
        else $error("set size above capacity");

    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[16:0] == 17'd0 && o_m_tlast)
        else $error("beat without entry is not a clean final beat");

    // only sorted reads give more than one beat, and each carries an entry
    a_mid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser[0] && !o_m_tdata[17])
        else $error("non-final beat without entry");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command taken while previous one in progress");

endmodule

bind mru_selection_set_top mss_checker u_mss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

### tb/sv/mru_selection_set_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_selection_set_top_test
// self-checking bench for the recently used selection set
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty set, index extremes,
// negative indices, values driven negative by after-remove and the unused
// op codes. Random commands follow, with fill runs that push the set to
// capacity and beyond, picks of stored indices so that hits are common, and
// a mix of all operations. A set copy predicts untyped beats; typed rows give
// their own flag and size. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module mru_selection_set_top_test;
    import mss_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_CMDS  = 280;
    localparam int IDLE_LIMIT   = 4000;
    localparam int END_CYCLES   = 100;

    typedef struct {
        logic [OP_W-1:0] op;
        int              idx;
        bit              typed;
        bit              exp_flag;
        int              exp_size;
    } t_cmd_row;

    typedef struct {
        logic [IDX_W-1:0]  entry;
        logic              entry_valid;
        logic              flag;
        logic [SIZE_W-1:0] set_size;
        logic              last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // index[16:0], zero fill
    logic [7:0]  i_s_tuser = '0;   // op[2:0], zero fill
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // entry[16:0], flag[17], set_size[24:18], zero fill
    logic [7:0]  o_m_tuser;        // entry_valid[0], zero fill
    logic        o_m_tlast;

    int    sel_list [CAPACITY];
    int    sel_count = 0;
    t_beat cmd_beats [$];
    t_beat due_beats [$];
    t_beat rx_want;

    int  n_errors = 0;
    int  beats_seen = 0;
    int  cmds_sent = 0;
    int  full_refusals = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    t_cmd_row dir_rows [DIR_ROWS];

    always #4 i_clk = ~i_clk;

    mru_selection_set_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    function automatic t_beat make_beat(input int entry, input bit valid, input bit flag,
                                        input int size, input bit last);
        t_beat b;
        b.entry       = IDX_W'(entry);
        b.entry_valid = valid;
        b.flag        = flag;
        b.set_size    = SIZE_W'(size);
        b.last        = last;
        return b;
    endfunction

    function automatic int find_sel(input int v);
        for (int k = 0; k < sel_count; k++) begin
            if (sel_list[k] == v) return k;
        end
        return -1;
    endfunction

    function automatic void drop_at(input int pos);
        for (int j = pos; j + 1 < sel_count; j++) sel_list[j] = sel_list[j + 1];
        sel_count--;
    endfunction

    // updates the set copy and leaves the beats of one command in cmd_beats
    function automatic void update_selection(input logic [OP_W-1:0] op,
                                             input logic signed [IDX_W-1:0] idx);
        int v;
        int pos;
        int t;
        int b;
        int srt [CAPACITY];
        bit flg;
        v   = idx;
        flg = 1'b0;
        pos = find_sel(v);
        cmd_beats.delete();
        case (op)
            OP_SET_SINGLE: begin
                sel_count = 0;
                if (v >= 0) begin
                    sel_list[0] = v;
                    sel_count   = 1;
                end
            end
            OP_TOGGLE: begin
                if (v >= 0) begin
                    if (pos >= 0) begin
                        drop_at(pos);
                    end else if (sel_count >= CAPACITY) begin
                        full_refusals++;
                    end else begin
                        for (int k = sel_count; k > 0; k--) sel_list[k] = sel_list[k - 1];
                        sel_list[0] = v;
                        sel_count++;
                        flg = 1'b1;
                    end
                end
            end
            OP_ERASE: begin
                if (pos >= 0) drop_at(pos);
            end
            OP_AFTER_REMOVE: begin
                if (pos >= 0) drop_at(pos);
                for (int k = 0; k < sel_count; k++) begin
                    if (sel_list[k] > v) sel_list[k]--;
                end
            end
            OP_CONTAINS: begin
                flg = (pos >= 0);
            end
            OP_READ_SORTED: begin
                if (sel_count > 0) begin
                    for (int a = 0; a < sel_count; a++) srt[a] = sel_list[a];
                    for (int a = 1; a < sel_count; a++) begin
                        t = srt[a];
                        b = a;
                        while (b > 0 && srt[b - 1] < t) begin
                            srt[b] = srt[b - 1];
                            b--;
                        end
                        srt[b] = t;
                    end
                    for (int a = 0; a < sel_count; a++) begin
                        cmd_beats.push_back(make_beat(srt[a], 1'b1, 1'b0, sel_count,
                                                      a + 1 == sel_count));
                    end
                    return;
                end
            end
            default: begin
            end
        endcase
        cmd_beats.push_back(make_beat(0, 1'b0, flg, sel_count, 1'b1));
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_idx();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 47);
        if (r < 70 && sel_count > 0) return sel_list[$urandom_range(0, sel_count - 1)];
        if (r < 90) return $urandom_range(0, 65535);
        return -1;
    endfunction

    task automatic issue_cmd(input logic [OP_W-1:0] op, input int idx, input bit typed,
                             input bit exp_flag, input int exp_size);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, IDX_W'(idx)};
        i_s_tuser  <= {5'd0, op};
        do @(posedge i_clk); while (!o_s_tready);
        update_selection(op, IDX_W'(idx));
        if (typed) begin
            due_beats.push_back(make_beat(0, 1'b0, exp_flag, exp_size, 1'b1));
        end else begin
            foreach (cmd_beats[k]) due_beats.push_back(cmd_beats[k]);
        end
        cmds_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_beats.size() > 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // result side: check beats and drive ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_beats.size() == 0) begin
                $error("unexpected beat: entry %0d, size %0d",
                       $signed(o_m_tdata[16:0]), o_m_tdata[24:18]);
                n_errors++;
            end else begin
                rx_want = due_beats.pop_front();
                check_field("entry", $signed(rx_want.entry), $signed(o_m_tdata[16:0]));
                check_field("entry_valid", rx_want.entry_valid, o_m_tuser[0]);
                check_field("flag", rx_want.flag, o_m_tdata[17]);
                check_field("set_size", rx_want.set_size, o_m_tdata[24:18]);
                check_field("last", rx_want.last, o_m_tlast);
                beats_seen++;
            end
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int r;
        int v;
        int runs;
        int rand_cmds;
        bit drained;
        dir_rows = '{
            '{OP_READ_SORTED,  0,     1'b1, 1'b0, 0},
            '{OP_CONTAINS,     0,     1'b1, 1'b0, 0},
            '{OP_TOGGLE,       -1,    1'b1, 1'b0, 0},
            '{OP_SET_SINGLE,   -1,    1'b1, 1'b0, 0},
            '{OP_SET_SINGLE,   65535, 1'b1, 1'b0, 1},
            '{OP_CONTAINS,     65535, 1'b1, 1'b1, 1},
            '{OP_TOGGLE,       65535, 1'b1, 1'b0, 0},
            '{OP_TOGGLE,       0,     1'b1, 1'b1, 1},
            '{OP_TOGGLE,       65535, 1'b1, 1'b1, 2},
            '{OP_TOGGLE,       21845, 1'b1, 1'b1, 3},
            '{OP_TOGGLE,       43690, 1'b1, 1'b1, 4},
            '{OP_READ_SORTED,  0,     1'b0, 1'b0, 0},
            '{OP_AFTER_REMOVE, 21845, 1'b1, 1'b0, 3},
            '{OP_CONTAINS,     43689, 1'b1, 1'b1, 3},
            '{OP_AFTER_REMOVE, -1,    1'b1, 1'b0, 3},
            '{OP_CONTAINS,     -1,    1'b1, 1'b1, 3},
            '{OP_READ_SORTED,  0,     1'b0, 1'b0, 0},
            '{OP_ERASE,        -1,    1'b1, 1'b0, 2},
            '{OP_ERASE,        12345, 1'b1, 1'b0, 2},
            '{OP_SPARE_A,      7,     1'b1, 1'b0, 2},
            '{OP_SPARE_B,      65535, 1'b1, 1'b0, 2},
            '{OP_AFTER_REMOVE, 0,     1'b0, 1'b0, 0},
            '{OP_SET_SINGLE,   0,     1'b1, 1'b0, 1},
            '{OP_READ_SORTED,  0,     1'b0, 1'b0, 0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            issue_cmd(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].typed,
                      dir_rows[k].exp_flag, dir_rows[k].exp_size);
        end

        rand_cmds = 0;
        drained   = 1'b0;
        while (rand_cmds < RANDOM_CMDS) begin
            quiet = ((rand_cmds / 60) % 4 == 2);
            if (!drained && rand_cmds >= RANDOM_CMDS / 2) begin
                wait_drained();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                // fill run: fresh indices until the set overflows
                runs = CAPACITY - sel_count + $urandom_range(1, 4);
                repeat (runs) begin
                    do v = $urandom_range(0, 65535); while (find_sel(v) >= 0);
                    issue_cmd(OP_TOGGLE, v, 1'b0, 1'b0, 0);
                    rand_cmds++;
                end
            end else if (r < 9) begin
                issue_cmd($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                          $urandom_range(0, 1) ? -1 : $urandom_range(0, 65535),
                          1'b0, 1'b0, 0);
                rand_cmds++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) issue_cmd(OP_TOGGLE, pick_idx(), 1'b0, 1'b0, 0);
                else if (r < 65) issue_cmd(OP_CONTAINS, pick_idx(), 1'b0, 1'b0, 0);
                else if (r < 75) issue_cmd(OP_ERASE, pick_idx(), 1'b0, 1'b0, 0);
                else if (r < 87) issue_cmd(OP_AFTER_REMOVE, pick_idx(), 1'b0, 1'b0, 0);
                else if (r < 97) issue_cmd(OP_READ_SORTED, pick_idx(), 1'b0, 1'b0, 0);
                else issue_cmd(OP_SET_SINGLE, pick_idx(), 1'b0, 1'b0, 0);
                rand_cmds++;
            end
        end

        quiet = 1'b0;
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("run covered %0d commands and %0d result beats", cmds_sent, beats_seen);
        $display("%0d toggles were refused on a full set", full_refusals);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
design/mss_pkg.sv
design/mss_ram.sv
design/mru_selection_set_top.sv
design/mss_checker.sv
tb/sv/mru_selection_set_top_test.sv
